>>> hw/rtl/wcafd_pkg.sv
// shared widths, limits and register index codes for the wca gradient block
// no dependencies
package wcafd_pkg;

    localparam int DISP_W  = 22;
    localparam int EPS_W   = 24;
    localparam int SIG_W   = 20;
    localparam int DR_W    = 16;
    localparam int OUT_W   = 48;
    localparam int OP_W    = 48;
    localparam int PROD_W  = 2 * OP_W;
    localparam int CFG_IDX_W = 2;
    localparam int IN_DATA_W = 48;
    localparam int OUT_DATA_W = 2 * OUT_W;

    localparam logic [OUT_W-1:0] CAP_POS = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] CAP_NEG = {1'b1, {(OUT_W-1){1'b0}}};

    localparam logic [CFG_IDX_W-1:0] CFG_WELL_DEPTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTACT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROBE_OFS  = 2'd2;

endpackage

>>> hw/rtl/wcafd_ser_mul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle
// also gives the product shifted down by the fraction bits, saturated
// uses wcafd_pkg
module wcafd_ser_mul #(
    parameter int FRAC = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [wcafd_pkg::OP_W-1:0]    i_a,
    input  logic [wcafd_pkg::OP_W-1:0]    i_b,
    output logic                          o_done,
    output logic [wcafd_pkg::PROD_W-1:0]  o_prod,
    output logic [wcafd_pkg::OP_W-1:0]    o_sat
);
    localparam int OW = wcafd_pkg::OP_W;
    localparam int PW = wcafd_pkg::PROD_W;
    localparam int CW = $clog2(OW + 1);

    logic [OW-1:0] r_a, r_b;
    logic [PW-1:0] r_acc;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic [OW:0]   w_sum;
    logic [PW-1:0] w_sh;

    assign w_sum = {1'b0, r_acc[PW-1:OW]} + (r_b[0] ? {1'b0, r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(OW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= {w_sum, r_acc[OW-1:1]};
            r_b   <= r_b >> 1;
        end
    end

    assign w_sh   = r_acc >> FRAC;
    assign o_done = r_done;
    assign o_prod = r_acc;
    assign o_sat  = (|w_sh[PW-1:OW-1]) ? wcafd_pkg::CAP_POS : {1'b0, w_sh[OW-2:0]};

endmodule

>>> hw/rtl/wcafd_ser_div.sv
// restoring divider, one quotient bit per cycle
// the dividend register shifts out the top bit and takes the quotient bit in
// uses wcafd_pkg
module wcafd_ser_div #(
    parameter int DW = 65
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [DW-1:0]               i_num,
    input  logic [wcafd_pkg::OP_W-1:0]  i_den,
    output logic                        o_done,
    output logic [DW-1:0]               o_quo
);
    localparam int OW = wcafd_pkg::OP_W;
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] r_num;
    logic [OW-1:0] r_rem, r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic [OW:0]   w_try, w_diff;
    logic          w_ge;

    assign w_try  = {r_rem, r_num[DW-1]};
    assign w_ge   = w_try >= {1'b0, r_den};
    assign w_diff = w_try - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[OW-1:0] : w_try[OW-1:0];
            r_num <= {r_num[DW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num;

endmodule

>>> hw/rtl/wca_finite_difference_gradient.sv
// wca potential gradient by central differences over a sample's neighbors
// one serial multiplier and one serial divider, shared under a sequencer
// non-self item: one product for sigma squared, then per probe up to six products and one division
// self item: no arithmetic; an item marked last adds the two gradient divisions
// the shared multiplier works one multiplier bit a cycle
// synchronous active-low reset: sums zero, config registers at defaults, no item pending
module wca_finite_difference_gradient #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  logic [wcafd_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,  // disp_x, disp_y, zero pad
    input  logic                                 i_s_axis_tuser,  // is_self
    input  logic                                 i_s_axis_tlast,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    output logic [wcafd_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,  // grad_x, grad_y
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [wcafd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [wcafd_pkg::EPS_W-1:0]          i_cfg_data
);
    localparam int OW = wcafd_pkg::OP_W;
    localparam int DVW = OW + 1 + FRAC_BITS;
    localparam int DW = wcafd_pkg::DISP_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SIG  = 4'd1;
    localparam logic [3:0] S_SQX  = 4'd2;
    localparam logic [3:0] S_SQY  = 4'd3;
    localparam logic [3:0] S_DIV  = 4'd4;
    localparam logic [3:0] S_Q2   = 4'd5;
    localparam logic [3:0] S_Q3   = 4'd6;
    localparam logic [3:0] S_Q6   = 4'd7;
    localparam logic [3:0] S_T    = 4'd8;
    localparam logic [3:0] S_ACC  = 4'd9;
    localparam logic [3:0] S_GX   = 4'd10;
    localparam logic [3:0] S_GY   = 4'd11;
    localparam logic [3:0] S_EMIT = 4'd12;

    logic [3:0]                       r_state;
    logic                             r_wait;
    logic [wcafd_pkg::EPS_W-1:0]      r_eps;
    logic [wcafd_pkg::SIG_W-1:0]      r_sig;
    logic [wcafd_pkg::DR_W-1:0]       r_dr;
    logic [DW-1:0]                    r_dx, r_dy;
    logic                             r_last;
    logic [1:0]                       r_p;
    logic signed [OW-1:0]             r_sum [4];
    logic [45:0]                      r_r2;
    logic [39:0]                      r_s2;
    logic [OW-1:0]                    r_q, r_q3, r_q6;
    logic [OW-1:0]                    r_u;
    logic [OW-1:0]                    r_gx;
    logic [OW-1:0]                    r_gy;
    logic                             r_ovalid;
    logic [wcafd_pkg::OUT_DATA_W-1:0] r_odata;

    logic                             w_mstart, w_mdone, w_dstart, w_ddone;
    logic [OW-1:0]                    w_ma, w_mb, w_msat;
    logic [wcafd_pkg::PROD_W-1:0]     w_mprod;
    logic [DVW-1:0]                   w_dnum, w_quo;
    logic [OW-1:0]                    w_dden;
    logic signed [DW:0]               w_offx, w_offy, w_px, w_py;
    logic [DW:0]                      w_ax, w_ay;
    logic signed [OW:0]               w_qd, w_t, w_uraw, w_acc, w_gd;
    logic [OW:0]                      w_qmag, w_gmag;
    logic [OW-1:0]                    w_qcap, w_gq, w_uval, w_accv;
    logic                             w_gzero;

    wcafd_ser_mul #(.FRAC(FRAC_BITS)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mstart),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_done  (w_mdone),
        .o_prod  (w_mprod),
        .o_sat   (w_msat)
    );

    wcafd_ser_div #(.DW(DVW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_num   (w_dnum),
        .i_den   (w_dden),
        .o_done  (w_ddone),
        .o_quo   (w_quo)
    );

    // probe vector: north, east, west, south
    always_comb begin
        w_offx = '0;
        w_offy = '0;
        case (r_p)
            2'd0: w_offy = $signed({7'd0, r_dr});
            2'd1: w_offx = $signed({7'd0, r_dr});
            2'd2: w_offx = -$signed({7'd0, r_dr});
            default: w_offy = -$signed({7'd0, r_dr});
        endcase
    end

    assign w_px = $signed({r_dx[DW-1], r_dx}) - w_offx;
    assign w_py = $signed({r_dy[DW-1], r_dy}) - w_offy;
    assign w_ax = w_px[DW] ? -w_px : w_px;
    assign w_ay = w_py[DW] ? -w_py : w_py;

    assign w_qd   = $signed({1'b0, r_q6}) - $signed({1'b0, r_q3});
    assign w_qmag = w_qd[OW] ? -w_qd : w_qd;
    assign w_t    = w_qd[OW] ? -$signed({1'b0, w_msat}) : $signed({1'b0, w_msat});
    assign w_uraw = w_t + $signed({25'd0, r_eps});
    assign w_uval = (w_uraw > $signed({1'b0, wcafd_pkg::CAP_POS})) ? wcafd_pkg::CAP_POS
                                                                   : w_uraw[OW-1:0];

    assign w_acc = $signed({r_sum[r_p][OW-1], r_sum[r_p]}) + $signed({r_u[OW-1], r_u});
    always_comb begin
        if (w_acc[OW] != w_acc[OW-1]) begin
            w_accv = w_acc[OW] ? wcafd_pkg::CAP_NEG : wcafd_pkg::CAP_POS;
        end else begin
            w_accv = w_acc[OW-1:0];
        end
    end

    // gradient numerator: east minus west, or north minus south
    assign w_gd = (r_state == S_GX)
                ? $signed({r_sum[1][OW-1], r_sum[1]}) - $signed({r_sum[2][OW-1], r_sum[2]})
                : $signed({r_sum[0][OW-1], r_sum[0]}) - $signed({r_sum[3][OW-1], r_sum[3]});
    assign w_gmag  = w_gd[OW] ? -w_gd : w_gd;
    assign w_gzero = (r_dr == '0) || (w_gd == '0);

    assign w_qcap = (|w_quo[DVW-1:OW-1]) ? wcafd_pkg::CAP_POS : {1'b0, w_quo[OW-2:0]};
    always_comb begin
        if (!w_gd[OW]) begin
            w_gq = w_qcap;
        end else if ((|w_quo[DVW-1:OW]) || (w_quo[OW-1] && (|w_quo[OW-2:0]))) begin
            w_gq = wcafd_pkg::CAP_NEG;
        end else begin
            w_gq = OW'(0) - w_quo[OW-1:0];
        end
    end

    // operand selection for the shared units
    always_comb begin
        w_mstart = 1'b0;
        w_dstart = 1'b0;
        w_ma = '0;
        w_mb = '0;
        w_dnum = DVW'({r_s2, FRAC_BITS'(0)});
        w_dden = {2'd0, r_r2};
        unique case (r_state)
            S_SIG: begin
                w_mstart = !r_wait;
                w_ma = OW'(r_sig);
                w_mb = OW'(r_sig);
            end
            S_SQX: begin
                w_mstart = !r_wait;
                w_ma = OW'(w_ax);
                w_mb = OW'(w_ax);
            end
            S_SQY: begin
                w_mstart = !r_wait;
                w_ma = OW'(w_ay);
                w_mb = OW'(w_ay);
            end
            S_DIV: begin
                w_dstart = !r_wait && (r_r2 != '0);
            end
            S_Q2: begin
                w_mstart = !r_wait;
                w_ma = r_q;
                w_mb = r_q;
            end
            S_Q3: begin
                w_mstart = !r_wait;
                w_ma = r_q6;
                w_mb = r_q;
            end
            S_Q6: begin
                w_mstart = !r_wait;
                w_ma = r_q3;
                w_mb = r_q3;
            end
            S_T: begin
                w_mstart = !r_wait;
                w_ma = OW'({r_eps, 2'b00});
                w_mb = w_qmag[OW-1:0];
            end
            S_GX, S_GY: begin
                w_dstart = !r_wait && !w_gzero;
                w_dnum = DVW'(w_gmag) << FRAC_BITS;
                w_dden = OW'({r_dr, 1'b0});
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= wcafd_pkg::EPS_W'(65536);
            r_sig <= wcafd_pkg::SIG_W'(65536);
            r_dr  <= wcafd_pkg::DR_W'(655);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                wcafd_pkg::CFG_WELL_DEPTH: r_eps <= i_cfg_data;
                wcafd_pkg::CFG_CONTACT:    r_sig <= i_cfg_data[wcafd_pkg::SIG_W-1:0];
                wcafd_pkg::CFG_PROBE_OFS:  r_dr  <= i_cfg_data[wcafd_pkg::DR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wait   <= 1'b0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_sum[i] <= '0;
            end
        end else begin
            if (r_ovalid && i_m_axis_tready && (r_state != S_EMIT)) begin
                r_ovalid <= 1'b0;
            end
            if (w_mstart || w_dstart) begin
                r_wait <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_dx   <= i_s_axis_tdata[DW-1:0];
                        r_dy   <= i_s_axis_tdata[2*DW-1:DW];
                        r_last <= i_s_axis_tlast;
                        r_p    <= 2'd0;
                        if (!i_s_axis_tuser) begin
                            r_state <= S_SIG;
                        end else if (i_s_axis_tlast) begin
                            r_state <= S_GX;
                        end
                    end
                end
                S_SIG: if (w_mdone) begin
                    r_s2    <= w_mprod[39:0];
                    r_wait  <= 1'b0;
                    r_state <= S_SQX;
                end
                S_SQX: if (w_mdone) begin
                    r_r2    <= w_mprod[45:0];
                    r_wait  <= 1'b0;
                    r_state <= S_SQY;
                end
                S_SQY: if (w_mdone) begin
                    r_r2    <= r_r2 + w_mprod[45:0];
                    r_wait  <= 1'b0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (!r_wait && r_r2 == '0) begin
                        // probe on top of the neighbor
                        r_u     <= wcafd_pkg::CAP_POS;
                        r_state <= S_ACC;
                    end else if (w_ddone) begin
                        r_q     <= w_qcap;
                        r_wait  <= 1'b0;
                        r_state <= S_Q2;
                    end
                end
                S_Q2: if (w_mdone) begin
                    r_q6    <= w_msat;
                    r_wait  <= 1'b0;
                    r_state <= S_Q3;
                end
                S_Q3: if (w_mdone) begin
                    r_q3    <= w_msat;
                    r_wait  <= 1'b0;
                    r_state <= S_Q6;
                end
                S_Q6: if (w_mdone) begin
                    r_q6    <= w_msat;
                    r_wait  <= 1'b0;
                    r_state <= S_T;
                end
                S_T: if (w_mdone) begin
                    r_u     <= w_uval;
                    r_wait  <= 1'b0;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_sum[r_p] <= w_accv;
                    r_p        <= r_p + 2'd1;
                    if (r_p != 2'd3) begin
                        r_state <= S_SQX;
                    end else begin
                        r_state <= r_last ? S_GX : S_IDLE;
                    end
                end
                S_GX: begin
                    if (!r_wait && w_gzero) begin
                        r_gx    <= '0;
                        r_state <= S_GY;
                    end else if (w_ddone) begin
                        r_gx    <= w_gq;
                        r_wait  <= 1'b0;
                        r_state <= S_GY;
                    end
                end
                S_GY: begin
                    if (!r_wait && w_gzero) begin
                        r_gy    <= '0;
                        r_state <= S_EMIT;
                    end else if (w_ddone) begin
                        r_gy    <= w_gq;
                        r_wait  <= 1'b0;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!r_ovalid || i_m_axis_tready) begin
                        r_odata  <= {r_gy, r_gx};
                        r_ovalid <= 1'b1;
                        for (int i = 0; i < 4; i++) begin
                            r_sum[i] <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output register only loads when it is empty or the previous item is being taken
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_cfg_ready     = 1'b1;

endmodule
